// ----- rtl/vsd_pkg.sv -----
// Shared types and constants of the dithered vertical scaler.
// Holds the register map, the configuration struct and the datapath widths.
// No dependencies.
package vsd_pkg;

  localparam int NUM_TAPS     = 8;
  localparam int SAMPLE_W     = 16;
  localparam int COEFF_W      = 16;
  localparam int PROD_W       = SAMPLE_W + COEFF_W;
  localparam int PAIR_W       = PROD_W + 1;
  localparam int QUAD_W       = PROD_W + 2;
  localparam int ACC_W        = PROD_W + 4;
  localparam int COLUMN_W     = 12;
  localparam int PHASE_W      = 3;
  localparam int DITHER_W     = 8;
  localparam int DITHER_SHIFT = 12;
  localparam int DTERM_W      = DITHER_W + DITHER_SHIFT;
  localparam int OUT_SHIFT    = 19;
  localparam int PIXEL_W      = 8;
  localparam int TAPCNT_W     = 4;
  localparam int DATA_W       = 64;
  localparam int ADDR_W       = 6;
  localparam int REGIDX_W     = 3;

  // Register indexes; byte address is 8 times the index.
  localparam logic [REGIDX_W-1:0] REG_TAP_COUNT      = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_COEFFS_LOW     = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_COEFFS_HIGH    = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_DITHER_PATTERN = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_DITHER_OFFSET  = 3'd4;

  localparam logic [TAPCNT_W-1:0] TAP_COUNT_RESET   = 4'd1;
  localparam logic [DATA_W-1:0]   COEFFS_LOW_RESET  = 64'd4096;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic [NUM_TAPS-1:0][SAMPLE_W-1:0] sample_vec_t;
  typedef logic [NUM_TAPS-1:0][PROD_W-1:0]   prod_vec_t;

  typedef struct packed {
    logic [TAPCNT_W-1:0] tap_count;
    logic [DATA_W-1:0]   coeffs_low;
    logic [DATA_W-1:0]   coeffs_high;
    logic [DATA_W-1:0]   dither_pattern;
    logic [PHASE_W-1:0]  dither_offset;
  } cfg_t;

endpackage

// ----- rtl/vsd_regs.sv -----
// Configuration register file of the dithered vertical scaler.
// APB-style write and read access; depends on vsd_pkg.
module vsd_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vsd_pkg::ADDR_W-1:0] paddr,
  input  logic [vsd_pkg::DATA_W-1:0] pwdata,
  output logic [vsd_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output vsd_pkg::cfg_t             cfg
);
  import vsd_pkg::*;

  cfg_t                cfg_r;
  logic                wr_en;
  logic [REGIDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-REGIDX_W];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tap_count      <= TAP_COUNT_RESET;
      cfg_r.coeffs_low     <= COEFFS_LOW_RESET;
      cfg_r.coeffs_high    <= '0;
      cfg_r.dither_pattern <= '0;
      cfg_r.dither_offset  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TAP_COUNT:      cfg_r.tap_count      <= pwdata[TAPCNT_W-1:0];
        REG_COEFFS_LOW:     cfg_r.coeffs_low     <= pwdata;
        REG_COEFFS_HIGH:    cfg_r.coeffs_high    <= pwdata;
        REG_DITHER_PATTERN: cfg_r.dither_pattern <= pwdata;
        REG_DITHER_OFFSET:  cfg_r.dither_offset  <= pwdata[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TAP_COUNT:      prdata = {{(DATA_W-TAPCNT_W){1'b0}}, cfg_r.tap_count};
      REG_COEFFS_LOW:     prdata = cfg_r.coeffs_low;
      REG_COEFFS_HIGH:    prdata = cfg_r.coeffs_high;
      REG_DITHER_PATTERN: prdata = cfg_r.dither_pattern;
      REG_DITHER_OFFSET:  prdata = {{(DATA_W-PHASE_W){1'b0}}, cfg_r.dither_offset};
      default:            prdata = '0;
    endcase
  end

endmodule

// ----- rtl/vsd_mult.sv -----
// Multiply stage: one signed 16x16 product per tap, plus dither term lookup.
// Depends on vsd_pkg.
module vsd_mult (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [vsd_pkg::COLUMN_W-1:0] in_column,
  input  vsd_pkg::sample_vec_t         in_samples,
  input  vsd_pkg::cfg_t                cfg,
  output logic                         prod_valid,
  output vsd_pkg::prod_vec_t           prod,
  output logic [vsd_pkg::DTERM_W-1:0]  dterm
);
  import vsd_pkg::*;

  logic                          valid_r;
  prod_vec_t                     prod_r;
  prod_vec_t                     prod_nxt;
  logic [DTERM_W-1:0]            dterm_r;
  logic [DTERM_W-1:0]            dterm_nxt;
  logic [PHASE_W-1:0]            phase;
  logic [NUM_TAPS*COEFF_W-1:0]   coeff_all;

  assign coeff_all = {cfg.coeffs_high, cfg.coeffs_low};
  assign phase     = in_column[PHASE_W-1:0] + cfg.dither_offset;
  assign dterm_nxt = {cfg.dither_pattern[{phase, 3'b000} +: DITHER_W],
                      {DITHER_SHIFT{1'b0}}};

  // Taps at or beyond the tap count contribute nothing.
  always_comb begin
    for (int j = 0; j < NUM_TAPS; j++) begin
      if (TAPCNT_W'(j) < cfg.tap_count) begin
        prod_nxt[j] = $signed(in_samples[j]) * $signed(coeff_all[j*COEFF_W +: COEFF_W]);
      end else begin
        prod_nxt[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    dterm_r <= dterm_nxt;
  end

  assign prod_valid = valid_r;
  assign prod       = prod_r;
  assign dterm      = dterm_r;

endmodule

// ----- rtl/vsd_sum.sv -----
// Registered adder tree with final shift and clip to an 8-bit pixel.
// Depends on vsd_pkg.
module vsd_sum (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         prod_valid,
  input  vsd_pkg::prod_vec_t           prod,
  input  logic [vsd_pkg::DTERM_W-1:0]  dterm,
  output logic                         out_valid,
  output logic [vsd_pkg::PIXEL_W-1:0]  out_pixel
);
  import vsd_pkg::*;

  logic                             pair_valid_r;
  logic signed [PAIR_W-1:0]         pair_r [NUM_TAPS/2];
  logic [DTERM_W-1:0]               dterm_r;
  logic                             quad_valid_r;
  logic signed [QUAD_W-1:0]         quad_lo_r;
  logic signed [QUAD_W:0]           quad_hi_r;
  logic                             out_valid_r;
  logic [PIXEL_W-1:0]               pixel_r;
  logic [PIXEL_W-1:0]               pixel_nxt;
  logic signed [ACC_W-1:0]          total;

  // Final sum and clip: negative gives 0, anything at or above 256 << 19 gives 255.
  assign total = ACC_W'(quad_lo_r) + ACC_W'(quad_hi_r);

  always_comb begin
    if (total[ACC_W-1]) begin
      pixel_nxt = '0;
    end else if (|total[ACC_W-2:OUT_SHIFT+PIXEL_W]) begin
      pixel_nxt = '1;
    end else begin
      pixel_nxt = total[OUT_SHIFT +: PIXEL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_valid_r <= 1'b0;
      quad_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pair_valid_r <= prod_valid;
      quad_valid_r <= pair_valid_r;
      out_valid_r  <= quad_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_TAPS/2; k++) begin
      pair_r[k] <= PAIR_W'($signed(prod[2*k])) + PAIR_W'($signed(prod[2*k+1]));
    end
    dterm_r   <= dterm;
    quad_lo_r <= QUAD_W'(pair_r[0]) + QUAD_W'(pair_r[1]);
    quad_hi_r <= (QUAD_W+1)'(pair_r[2]) + (QUAD_W+1)'(pair_r[3])
               + $signed({{(QUAD_W+1-DTERM_W){1'b0}}, dterm_r});
    pixel_r   <= pixel_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = pixel_r;

endmodule

// ----- rtl/vertical_scaler_dithered_top.sv -----
// Dithered eight-tap vertical scaler: the products, pair sums, quad sums and output
// stages each hold one register. Throughput is one column per cycle; busy stays low.
// rst_n is synchronous and active low: it clears the pipeline valid bits and loads
// the register reset values (tap_count 1, coeffs_low 4096, all others 0).
module vertical_scaler_dithered_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // Command channel.
  input  logic                         start,
  output logic                         busy,
  input  logic [vsd_pkg::COLUMN_W-1:0] in_column,
  input  logic signed [15:0]           in_tap0_sample,
  input  logic signed [15:0]           in_tap1_sample,
  input  logic signed [15:0]           in_tap2_sample,
  input  logic signed [15:0]           in_tap3_sample,
  input  logic signed [15:0]           in_tap4_sample,
  input  logic signed [15:0]           in_tap5_sample,
  input  logic signed [15:0]           in_tap6_sample,
  input  logic signed [15:0]           in_tap7_sample,
  // Result channel.
  output logic                         out_valid,
  output logic [vsd_pkg::PIXEL_W-1:0]  out_pixel,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vsd_pkg::ADDR_W-1:0]   paddr,
  input  logic [vsd_pkg::DATA_W-1:0]   pwdata,
  output logic [vsd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import vsd_pkg::*;

  cfg_t               cfg;
  sample_vec_t        samples;
  prod_vec_t          prod;
  logic               prod_valid;
  logic [DTERM_W-1:0] dterm;
  logic               accept;

  // The pipeline never stalls, since results cannot be held off, so a new beat can be
  // taken in every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign samples = {in_tap7_sample, in_tap6_sample, in_tap5_sample, in_tap4_sample,
                    in_tap3_sample, in_tap2_sample, in_tap1_sample, in_tap0_sample};

  // Register file. The user must change configuration only while no beat is in flight; the block does not enforce it.
  vsd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // First stage: eight products in parallel and the dither term for this column.
  vsd_mult u_mult (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (accept),
    .in_column  (in_column),
    .in_samples (samples),
    .cfg        (cfg),
    .prod_valid (prod_valid),
    .prod       (prod),
    .dterm      (dterm)
  );

  // Remaining stages: two levels of adders, then the final add with shift and clip.
  vsd_sum u_sum (
    .clk        (clk),
    .rst_n      (rst_n),
    .prod_valid (prod_valid),
    .prod       (prod),
    .dterm      (dterm),
    .out_valid  (out_valid),
    .out_pixel  (out_pixel)
  );

  // A beat in the product stage reaches the output through the pair, quad and output registers.
  a_prod_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    prod_valid |=> ##2 out_valid)
    else $error("product beat did not reach the output");

  // No result appears without a matching product beat before it.
  a_out_from_prod: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(prod_valid, 3))
    else $error("result beat without a matching product beat");

  // An accepted command always enters the product stage on the next edge.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> prod_valid)
    else $error("accepted beat lost before the product stage");

endmodule

// ----- bench/scaler_checker.sv -----
// Checker for the dithered vertical scaler: it watches the command, result and register ports,
// predicts every pixel and compares it with the result beats.
// Depends on vsd_pkg for the register map, the widths and the configuration struct.
`timescale 1ns / 1ps

import vsd_pkg::*;

module scaler_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [COLUMN_W-1:0] column,
  input  sample_vec_t         samples,
  input  logic                out_valid,
  input  logic [PIXEL_W-1:0]  out_pixel,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic [DATA_W-1:0]   prdata,
  input  logic                pready,
  output int                  mismatches,
  output int                  outstanding,
  output int                  pixels_checked
);

  typedef struct {
    logic [COLUMN_W-1:0] column;
    logic [PIXEL_W-1:0]  pixel;
  } pixel_expect_t;

  cfg_t            scaler_regs;
  pixel_expect_t   expected_pixels[$];
  pixel_expect_t   oldest;
  pixel_expect_t   fresh;
  logic [REGIDX_W-1:0] reg_idx;

  // Dither term plus the products of the taps in use, shifted down and clipped.
  function automatic logic [PIXEL_W-1:0] filtered_pixel(input cfg_t regs,
                                                        input logic [COLUMN_W-1:0] col,
                                                        input sample_vec_t s);
    logic [PHASE_W-1:0]  phase;
    logic signed [47:0]  acc;
    logic signed [15:0]  coeff;
    logic [DATA_W-1:0]   word;
    int                  taps;
    int                  j;
    taps  = (regs.tap_count > NUM_TAPS) ? NUM_TAPS : int'(regs.tap_count);
    phase = col[PHASE_W-1:0] + regs.dither_offset;
    acc   = {28'd0, regs.dither_pattern[phase*DITHER_W +: DITHER_W], 12'd0};
    for (j = 0; j < NUM_TAPS; j++) begin
      if (j < taps) begin
        word  = (j < 4) ? regs.coeffs_low : regs.coeffs_high;
        coeff = word[(j % 4)*COEFF_W +: COEFF_W];
        acc   = acc + $signed(s[j]) * coeff;
      end
    end
    if (acc < 0)
      return '0;
    else if ((acc >>> OUT_SHIFT) > 255)
      return '1;
    else
      return acc[OUT_SHIFT +: PIXEL_W];
  endfunction

  function automatic logic [DATA_W-1:0] register_value(input cfg_t regs,
                                                       input logic [REGIDX_W-1:0] idx);
    case (idx)
      REG_TAP_COUNT:      return DATA_W'(regs.tap_count);
      REG_COEFFS_LOW:     return regs.coeffs_low;
      REG_COEFFS_HIGH:    return regs.coeffs_high;
      REG_DITHER_PATTERN: return regs.dither_pattern;
      REG_DITHER_OFFSET:  return DATA_W'(regs.dither_offset);
      default:            return '0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      scaler_regs.tap_count      = TAP_COUNT_RESET;
      scaler_regs.coeffs_low     = COEFFS_LOW_RESET;
      scaler_regs.coeffs_high    = '0;
      scaler_regs.dither_pattern = '0;
      scaler_regs.dither_offset  = '0;
      expected_pixels.delete();
      mismatches     = 0;
      pixels_checked = 0;
    end else begin
      if (out_valid) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: pixel beat expected none, got %0d", $time, out_pixel);
          mismatches++;
        end else begin
          oldest = expected_pixels.pop_front();
          if (out_pixel !== oldest.pixel) begin
            $display("%0t: column %0d pixel expected %0d, got %0d",
                     $time, oldest.column, oldest.pixel, out_pixel);
            mismatches++;
          end
          pixels_checked++;
        end
      end
      // The beat taken at this edge uses the registers as they were before it.
      if (start && !busy) begin
        fresh.column = column;
        fresh.pixel  = filtered_pixel(scaler_regs, column, samples);
        expected_pixels.push_back(fresh);
      end
      if (psel && penable && pready) begin
        reg_idx = paddr[ADDR_W-1 -: REGIDX_W];
        if (pwrite) begin
          case (reg_idx)
            REG_TAP_COUNT:      scaler_regs.tap_count      = pwdata[TAPCNT_W-1:0];
            REG_COEFFS_LOW:     scaler_regs.coeffs_low     = pwdata;
            REG_COEFFS_HIGH:    scaler_regs.coeffs_high    = pwdata;
            REG_DITHER_PATTERN: scaler_regs.dither_pattern = pwdata;
            REG_DITHER_OFFSET:  scaler_regs.dither_offset  = pwdata[PHASE_W-1:0];
            default: ;
          endcase
        end else if (reg_idx <= REG_DITHER_OFFSET &&
                     prdata !== register_value(scaler_regs, reg_idx)) begin
          $display("%0t: register %0d read expected %h, got %h",
                   $time, reg_idx, register_value(scaler_regs, reg_idx), prdata);
          mismatches++;
        end
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the scaler testbench: clock, reset, command beats, register writes and the verdict.
// Depends on vsd_pkg, vertical_scaler_dithered_top and scaler_checker.
`timescale 1ns / 1ps

import vsd_pkg::*;

module testbench;

  // A run with no accepted beat, no result beat and no register access for this many cycles is hung.
  localparam int QUIET_LIMIT  = 2000;
  // Idle wait at the end, after every pixel in flight has come back.
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_GAP      = 40;
  localparam int PHASES       = 8;
  localparam int PHASE_BEATS  = 79;

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [COLUMN_W-1:0] column;
  sample_vec_t         samples;
  logic                out_valid;
  logic [PIXEL_W-1:0]  out_pixel;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int mismatches;
  int outstanding;
  int pixels_checked;
  int columns_sent;
  int settings_applied;
  int idle_pct;
  int quiet_cycles;

  vertical_scaler_dithered_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_column      (column),
    .in_tap0_sample (samples[0]),
    .in_tap1_sample (samples[1]),
    .in_tap2_sample (samples[2]),
    .in_tap3_sample (samples[3]),
    .in_tap4_sample (samples[4]),
    .in_tap5_sample (samples[5]),
    .in_tap6_sample (samples[6]),
    .in_tap7_sample (samples[7]),
    .out_valid      (out_valid),
    .out_pixel      (out_pixel),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // The checker sees exactly what the block sees and reports back a mismatch count.
  scaler_checker pixel_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .column         (column),
    .samples        (samples),
    .out_valid      (out_valid),
    .out_pixel      (out_pixel),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .pixels_checked (pixels_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: any accepted beat, result beat or register access counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog expired after %0d quiet cycles", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic sample_vec_t fill_samples(input sample_t v);
    return {NUM_TAPS{v}};
  endfunction

  // Tame samples mostly sit in the upper half of the range so that realistic filters land
  // inside 0..255; wild ones cover every bit pattern.
  function automatic sample_vec_t random_samples(input bit wild);
    sample_vec_t s;
    int          k;
    for (k = 0; k < NUM_TAPS; k++) begin
      if (wild || $urandom_range(0, 7) == 0)
        s[k] = 16'($urandom);
      else
        s[k] = 16'($urandom_range(0, 32767));
    end
    return s;
  endfunction

  // Realistic coefficients fall in -256..1535; wild ones are any 16-bit value.
  function automatic logic [DATA_W-1:0] random_coeffs(input bit wild);
    logic [DATA_W-1:0] w;
    int                k;
    for (k = 0; k < 4; k++) begin
      if (wild)
        w[k*COEFF_W +: COEFF_W] = 16'($urandom);
      else
        w[k*COEFF_W +: COEFF_W] = 16'($urandom_range(0, 1791) - 256);
    end
    return w;
  endfunction

  // One command beat, preceded by a random idle gap. start stays high between
  // back-to-back beats and only drops when the sender actually idles.
  task automatic send_column(input logic [COLUMN_W-1:0] col, input sample_vec_t s);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
      gap++;
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    column  = col;
    samples = s;
    start   = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    columns_sent++;
  endtask

  // Stop issuing columns and wait until every pixel already in flight has come back.
  task automatic quiesce();
    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the transfer completes at the edge where pready is high.
  task automatic reg_access(input logic wr, input logic [REGIDX_W-1:0] idx,
                            input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 3'b000};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Programs all five registers while the block is idle, pokes one address past the map
  // (which must change nothing), then reads every register back for the checker.
  task automatic apply_setting(input logic [DATA_W-1:0] tap_word,
                               input logic [DATA_W-1:0] low_word,
                               input logic [DATA_W-1:0] high_word,
                               input logic [DATA_W-1:0] dither_word,
                               input logic [DATA_W-1:0] offset_word);
    int i;
    quiesce();
    reg_access(1'b1, REG_TAP_COUNT, tap_word);
    reg_access(1'b1, REG_COEFFS_LOW, low_word);
    reg_access(1'b1, REG_COEFFS_HIGH, high_word);
    reg_access(1'b1, REG_DITHER_PATTERN, dither_word);
    reg_access(1'b1, REG_DITHER_OFFSET, offset_word);
    reg_access(1'b1, REGIDX_W'($urandom_range(REG_DITHER_OFFSET + 1, (1 << REGIDX_W) - 1)),
               {$urandom, $urandom});
    for (i = REG_TAP_COUNT; i <= REG_DITHER_OFFSET; i++)
      reg_access(1'b0, REGIDX_W'(i), '0);
    settings_applied++;
  endtask

  initial begin
    logic [DATA_W-1:0] tap_word;
    int                phase;
    int                k;
    bit                wild_coeffs;

    rst_n            = 1'b0;
    start            = 1'b0;
    column           = '0;
    samples          = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    columns_sent     = 0;
    settings_applied = 0;
    idle_pct         = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Reset registers: one tap at unity gain, so the pixel is the sample over 128.
    // Full-scale positive gives 255 without clipping, full-scale negative clips to zero.
    send_column('0, fill_samples(SAMPLE_MAX));
    send_column('1, fill_samples(SAMPLE_MIN));
    send_column(COLUMN_W'(5), fill_samples(16'sd12800));

    // Every tap in use at the largest positive coefficient, full dither.
    apply_setting(DATA_W'(NUM_TAPS), {4{16'h7FFF}}, {4{16'h7FFF}}, '1, DATA_W'(7));
    send_column(COLUMN_W'(1), fill_samples(SAMPLE_MAX));
    send_column(COLUMN_W'(2), fill_samples(SAMPLE_MIN));
    send_column(COLUMN_W'(3), {4{SAMPLE_MIN, SAMPLE_MAX}});
    send_column(COLUMN_W'(4), fill_samples(16'sd0));

    // Zero taps, with junk in the upper bits of both narrow registers: dither alone.
    apply_setting(64'hFFFF_FFFF_FFFF_FFF0, {4{16'h7FFF}}, {4{16'h7FFF}}, '1,
                  64'hFFFF_FFFF_FFFF_FFF8);
    send_column(COLUMN_W'(6), fill_samples(SAMPLE_MAX));
    send_column(COLUMN_W'(7), fill_samples(SAMPLE_MIN));

    // A tap count of 15 saturates to eight taps; most negative coefficients everywhere.
    apply_setting(64'hF, {4{16'h8000}}, {4{16'h8000}}, '0, DATA_W'(3));
    send_column(COLUMN_W'(8), fill_samples(SAMPLE_MIN));
    send_column(COLUMN_W'(9), fill_samples(SAMPLE_MAX));

    // Three taps: large samples on the unused taps must not reach the sum.
    apply_setting(DATA_W'(3), {4{16'h7FFF}}, {4{16'h7FFF}}, 64'h8080_8080_8080_8080, '0);
    send_column(COLUMN_W'(10), {{5{SAMPLE_MAX}}, {3{16'sh0000}}});
    send_column(COLUMN_W'(11), {{5{SAMPLE_MIN}}, {3{16'sh0100}}});

    // Dither phase sweep: distinct bytes, offset 5, the eight highest columns.
    apply_setting(DATA_W'(1), DATA_W'(4096), '0, 64'hE0C0_A080_6040_2000, DATA_W'(5));
    for (k = 0; k < 8; k++)
      send_column(COLUMN_W'(4088 + k), fill_samples(16'sd96));

    // Random phases. The sender idles heavily in some, lightly in others, not at all in
    // the rest; the result side has no back-pressure to exercise.
    for (phase = 0; phase < PHASES; phase++) begin
      tap_word = {$urandom, $urandom};
      if (phase == 0)
        tap_word[TAPCNT_W-1:0] = TAPCNT_W'(NUM_TAPS);
      else if (phase == 1)
        tap_word[TAPCNT_W-1:0] = TAPCNT_W'(1);
      else if ($urandom_range(0, 5) == 0)
        tap_word[TAPCNT_W-1:0] = TAPCNT_W'($urandom_range(0, 15));
      else
        tap_word[TAPCNT_W-1:0] = TAPCNT_W'($urandom_range(1, NUM_TAPS));
      wild_coeffs = (phase % 3 == 2);
      apply_setting(tap_word, random_coeffs(wild_coeffs), random_coeffs(wild_coeffs),
                    {$urandom, $urandom}, {$urandom, $urandom});
      case (phase % 4)
        1:       idle_pct = 80;
        3:       idle_pct = 19;
        default: idle_pct = 0;
      endcase
      repeat (PHASE_BEATS)
        send_column(COLUMN_W'($urandom), random_samples($urandom_range(0, 3) == 0));
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d columns under %0d register settings; %0d pixels compared.",
             columns_sent, settings_applied, pixels_checked);
    $display("Covered zero, saturated and unused taps, clipping at both ends and all dither phases.");
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
